// File: hdl/pcn_pkg.sv
// ----------------------------------------------------------------------------
// pcn_pkg
// Shared types and constants for the percentile clip and normalise block.
// ----------------------------------------------------------------------------
package pcn_pkg;

	localparam int MAX_PIXELS  = 4096;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = $clog2(MAX_PIXELS);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int MAG_W       = SAMPLE_BITS - 1;
	localparam int PCT_W       = 7;
	localparam int PCT_MAX     = 100;
	localparam int PCT_RESET   = 100;
	// floor(x/100) == (x*RECIP_100) >> RECIP_SHIFT for x < 2^19
	localparam int RECIP_100   = 671089;
	localparam int RECIP_SHIFT = 26;
	localparam int PROD_W      = PCT_W + CNT_W;
	localparam int RECIP_W     = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int PIX_W       = 8;
	localparam int NUM_W       = SAMPLE_BITS + PIX_W;

	typedef struct packed {
		logic                          command;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_sample;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last_pixel;
	} out_item_t;

	typedef enum logic [1:0] {
		CLS_LOAD,
		CLS_LAST,
		CLS_READ
	} cls_t;

	typedef struct packed {
		cls_t                          cls;
		logic signed [SAMPLE_BITS-1:0] sample;
	} qent_t;

endpackage

// File: hdl/pcn_ram.sv
// ----------------------------------------------------------------------------
// pcn_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcn_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/pcn_front.sv
// ----------------------------------------------------------------------------
// pcn_front
// Accepts items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module pcn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pcn_pkg::in_item_t in_item,
	output logic              head_valid,
	output pcn_pkg::qent_t    head,
	input  logic              pop
);

	pcn_pkg::qent_t             ent_q [pcn_pkg::QUEUE_DEPTH];
	logic [pcn_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [pcn_pkg::QPTR_W:0]   fill_q;
	logic                       push, do_pop;
	pcn_pkg::qent_t             new_ent;

	assign in_stall   = (fill_q == (pcn_pkg::QPTR_W+1)'(pcn_pkg::QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign head_valid = (fill_q != '0);
	assign head       = ent_q[rptr_q];
	assign do_pop     = pop && head_valid;

	always_comb begin
		new_ent.sample = in_item.sample;
		if (in_item.command)          new_ent.cls = pcn_pkg::CLS_READ;
		else if (in_item.last_sample) new_ent.cls = pcn_pkg::CLS_LAST;
		else                          new_ent.cls = pcn_pkg::CLS_LOAD;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push)   wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (push && !do_pop)      fill_q <= fill_q + 1'b1;
			else if (!push && do_pop) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// File: hdl/pcn_div.sv
// ----------------------------------------------------------------------------
// pcn_div
// Restoring divider, one quotient bit a cycle, round to nearest even.
// ----------------------------------------------------------------------------
module pcn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pcn_pkg::NUM_W-1:0]         num,
	input  logic [pcn_pkg::SAMPLE_BITS-1:0]   den,
	output logic                              busy,
	output logic                              done,
	output logic [pcn_pkg::PIX_W-1:0]         pixel
);

	logic [pcn_pkg::NUM_W-1:0]       rem_q, dsh_q;
	logic [pcn_pkg::SAMPLE_BITS-1:0] den_q;
	logic [pcn_pkg::PIX_W-1:0]       quo_q;
	logic [2:0]                      step_q;
	logic                            busy_q, done_q;
	logic                            ge, inc;
	logic [pcn_pkg::SAMPLE_BITS:0]   r2;

	assign ge    = (rem_q >= dsh_q);
	assign busy  = busy_q;
	assign done  = done_q;
	assign r2    = {rem_q[pcn_pkg::SAMPLE_BITS-1:0], 1'b0};
	assign inc   = (r2 > {1'b0, den_q}) || ((r2 == {1'b0, den_q}) && quo_q[0]);
	assign pixel = (quo_q == '1) ? quo_q : quo_q + {{(pcn_pkg::PIX_W-1){1'b0}}, inc};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {1'b0, den, {(pcn_pkg::PIX_W-1){1'b0}}};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[pcn_pkg::PIX_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'(pcn_pkg::PIX_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hdl/pcn_back.sv
// ----------------------------------------------------------------------------
// pcn_back
// Executes queued items: sample store, clip level search, min/max, readout.
// ----------------------------------------------------------------------------
module pcn_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pcn_pkg::PCT_W-1:0]      cfg_data,
	input  logic                           head_valid,
	input  pcn_pkg::qent_t                 head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pcn_pkg::out_item_t             out_item
);

	typedef enum logic [3:0] {
		S_IDLE, S_SWEEP, S_K1, S_K2, S_K3, S_BS_NEXT, S_RD, S_MAP, S_DIV, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		M_NZ, M_BS, M_MM
	} mode_t;

	localparam int SB = pcn_pkg::SAMPLE_BITS;
	localparam int MW = pcn_pkg::MAG_W;
	localparam int CW = pcn_pkg::CNT_W;
	localparam logic [MW-1:0] MAG_MAX = '1;

	state_t                         state_q;
	mode_t                          mode_q;
	logic [pcn_pkg::PCT_W-1:0]      pct_q;
	logic [CW-1:0]                  cnt_q, pos_q, scan_q, hits_q, k_q;
	logic                           complete_q, rdv_s1, first_q;
	logic [MW-1:0]                  level_q, lo_q, hi_q, mid_q;
	logic signed [SB-1:0]           min_q, max_q, c_q;
	logic [pcn_pkg::PROD_W-1:0]     prod_q;
	logic [pcn_pkg::PROD_W+pcn_pkg::RECIP_W-1:0] kprod_q;
	logic                           flat_q;
	logic [pcn_pkg::PIX_W-1:0]      pix_q;
	logic                           out_valid_q;
	pcn_pkg::out_item_t             out_q;

	logic                           ram_we;
	logic [pcn_pkg::ADDR_W-1:0]     raddr;
	logic [SB-1:0]                  rdata;
	logic signed [SB-1:0]           rs, clipped;
	logic [MW-1:0]                  mag;
	logic [CW-1:0]                  k_new;
	logic [pcn_pkg::PCT_W-1:0]      pct_sat;
	logic                           is_load;
	logic signed [SB:0]             nn, dd;
	logic [SB-1:0]                  n24;
	logic                           div_start, div_busy, div_done;
	logic [pcn_pkg::PIX_W-1:0]      div_pix;
	logic [pcn_pkg::NUM_W-1:0]      num;
	logic                           out_free;

	function automatic logic signed [SB-1:0] clip_to(input logic signed [SB-1:0] s,
		input logic [MW-1:0] lvl);
		logic signed [SB-1:0] l;
		l = $signed({1'b0, lvl});
		if (s > l)       return l;
		else if (s < -l) return -l;
		else             return s;
	endfunction

	assign rs      = $signed(rdata);
	assign clipped = clip_to(rs, level_q);

	always_comb begin
		logic [SB-1:0] neg;
		neg = -rdata;
		if (!rs[SB-1])                 mag = rdata[MW-1:0];
		else if (neg[SB-1])            mag = MAG_MAX;
		else                           mag = neg[MW-1:0];
	end

	assign is_load  = (head.cls == pcn_pkg::CLS_LOAD) || (head.cls == pcn_pkg::CLS_LAST);
	assign pop      = (state_q == S_IDLE) && head_valid;
	assign ram_we   = pop && is_load && !complete_q && (cnt_q < CW'(pcn_pkg::MAX_PIXELS));
	assign raddr    = (state_q == S_SWEEP) ? scan_q[pcn_pkg::ADDR_W-1:0]
	                                        : pos_q[pcn_pkg::ADDR_W-1:0];
	assign pct_sat  = (pct_q > pcn_pkg::PCT_W'(pcn_pkg::PCT_MAX))
	                  ? pcn_pkg::PCT_W'(pcn_pkg::PCT_MAX) : pct_q;
	assign k_new    = kprod_q[pcn_pkg::RECIP_SHIFT +: CW];
	assign out_free = !out_valid_q || !out_stall;

	// clipped sample never lies below the clipped minimum, so n stays in [0, d]
	assign nn  = {c_q[SB-1], c_q} - {min_q[SB-1], min_q};
	assign dd  = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
	assign n24 = nn[SB] ? '0 : ((nn > dd) ? dd[SB-1:0] : nn[SB-1:0]);
	assign num = {n24, {pcn_pkg::PIX_W{1'b0}}} - {{pcn_pkg::PIX_W{1'b0}}, n24};
	assign div_start = (state_q == S_MAP) && !flat_q;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	pcn_ram #(.W(SB), .DEPTH(pcn_pkg::MAX_PIXELS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[pcn_pkg::ADDR_W-1:0]),
		.wdata (head.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	pcn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (dd[SB-1:0]),
		.busy   (div_busy),
		.done   (div_done),
		.pixel  (div_pix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_NZ;
			pct_q       <= pcn_pkg::PCT_W'(pcn_pkg::PCT_RESET);
			cnt_q       <= '0;
			pos_q       <= '0;
			complete_q  <= 1'b0;
			level_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			c_q         <= '0;
			scan_q      <= '0;
			hits_q      <= '0;
			k_q         <= '0;
			rdv_s1      <= 1'b0;
			first_q     <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			prod_q      <= '0;
			kprod_q     <= '0;
			pix_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			flat_q      <= 1'b0;
		end else begin
			if (cfg_we) pct_q <= cfg_data;
			// S_OUT sets it again when a new pixel goes out
			if (out_valid_q && !out_stall && state_q != S_OUT) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						if (is_load && !complete_q) begin
							if (ram_we) cnt_q <= cnt_q + 1'b1;
							if (head.cls == pcn_pkg::CLS_LAST) begin
								mode_q  <= M_NZ;
								scan_q  <= '0;
								hits_q  <= '0;
								rdv_s1  <= 1'b0;
								state_q <= S_SWEEP;
							end
						end else if (!is_load && complete_q) begin
							state_q <= S_RD;
						end
					end
				end
				S_SWEEP: begin
					rdv_s1 <= (scan_q < cnt_q);
					if (scan_q < cnt_q) scan_q <= scan_q + 1'b1;
					if (rdv_s1) begin
						unique case (mode_q)
							M_NZ: if (mag != '0) hits_q <= hits_q + 1'b1;
							M_BS: if (mag != '0 && mag <= mid_q) hits_q <= hits_q + 1'b1;
							M_MM: begin
								if (first_q || clipped < min_q) min_q <= clipped;
								if (first_q || clipped > max_q) max_q <= clipped;
								first_q <= 1'b0;
							end
							default: ;
						endcase
					end
					if (scan_q == cnt_q && !rdv_s1) begin
						unique case (mode_q)
							M_NZ: state_q <= S_K1;
							M_BS: begin
								if (hits_q >= k_q) hi_q <= mid_q;
								else               lo_q <= mid_q + 1'b1;
								state_q <= S_BS_NEXT;
							end
							M_MM: begin
								complete_q <= 1'b1;
								state_q    <= S_IDLE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_K1: begin
					prod_q  <= pcn_pkg::PROD_W'(pct_sat) * pcn_pkg::PROD_W'(hits_q);
					state_q <= S_K2;
				end
				S_K2: begin
					kprod_q <= prod_q * pcn_pkg::RECIP_W'(pcn_pkg::RECIP_100);
					state_q <= S_K3;
				end
				S_K3: begin
					k_q <= k_new;
					if (k_new == '0) begin
						level_q <= '0;
						mode_q  <= M_MM;
						scan_q  <= '0;
						rdv_s1  <= 1'b0;
						first_q <= 1'b1;
						state_q <= S_SWEEP;
					end else begin
						lo_q    <= MW'(1);
						hi_q    <= MAG_MAX;
						state_q <= S_BS_NEXT;
					end
				end
				S_BS_NEXT: begin
					scan_q <= '0;
					rdv_s1 <= 1'b0;
					hits_q <= '0;
					if (lo_q < hi_q) begin
						mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
						mode_q  <= M_BS;
					end else begin
						level_q <= lo_q;
						mode_q  <= M_MM;
						first_q <= 1'b1;
					end
					state_q <= S_SWEEP;
				end
				S_RD: begin
					c_q     <= clipped;
					flat_q  <= (max_q <= min_q);
					state_q <= S_MAP;
				end
				S_MAP: begin
					if (flat_q) begin
						pix_q   <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						pix_q   <= div_pix;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.pixel      <= pix_q;
						out_q.last_pixel <= (pos_q + 1'b1 >= cnt_q);
						if (pos_q + 1'b1 >= cnt_q) begin
							pos_q      <= '0;
							cnt_q      <= '0;
							complete_q <= 1'b0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_complete_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (cnt_q != '0))
		else $error("complete image with empty store");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> (pos_q < cnt_q))
		else $error("readout position beyond image");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (scan_q <= cnt_q))
		else $error("sweep address beyond image");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// File: hdl/percentile_clip_normalize_8bit.sv
// ----------------------------------------------------------------------------
// percentile_clip_normalize_8bit
// Percentile clipping of a signed image with min/max scaling to 8-bit grey.
// ----------------------------------------------------------------------------
// Items carry a command: load a sample, or read out the next pixel. Loads
// fill a 4096-entry store, one item a cycle when not stalled, through a
// four-item queue; a sample beyond the store is dropped. The item marked last
// starts the level selection, which runs over the single read port of the
// store: one pass to count nonzero magnitudes, states S_K1 to S_K3 to form
// floor(percentile*count/100), up to 23 binary-search passes (each a set-up
// state plus a sweep), and a final pass for the clipped min/max; items queue
// meanwhile. Each readout then goes through store read, clip, the serial
// divider at one quotient bit a cycle (a flat image gives 0 without it),
// round and output register. Loads while an image is complete and readouts
// before it is complete are swallowed. The percentile register may be
// written at any idle time; values above 100 act as 100. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module percentile_clip_normalize_8bit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  pcn_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output pcn_pkg::out_item_t          out_item,
	input  logic                        cfg_we,
	input  logic [pcn_pkg::PCT_W-1:0]   cfg_data
);

	// classified items between front and back
	logic           head_valid;
	pcn_pkg::qent_t head;
	logic           pop;

	pcn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pcn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule
